// ===== design/hll_pkg.sv =====
// Shared types and constants for the HLL interface flux core.
// No dependencies; imported by the core top level.
package hll_pkg;

    // width of the gas_gamma register
    localparam int GAMMA_BITS = 26;

    // sideband width on the result channel: wave_region then invalid_state
    localparam int USER_BITS = 3;

    // which flux the interface takes
    typedef enum logic [1:0] {
        REGION_LEFT  = 2'd0,
        REGION_RIGHT = 2'd1,
        REGION_HLL   = 2'd2
    } region_t;

endpackage

// ===== design/hll_div.sv =====
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
// Stand-alone datapath: load register, restoring step registers and a saturating output register.
module hll_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [WORD_BITS-1:0] num,
    input  logic signed [WORD_BITS-1:0] den,
    output logic signed [WORD_BITS-1:0] quo
);

    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int N = W + F;

    logic [W-1:0] rem_reg [0:N-1];
    logic [W-1:0] dvs_reg [0:N-1];
    logic [N-1:0] acc_reg [0:N];
    logic         neg_reg [0:N];
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [N-1:0] lim;
    logic [N-1:0] mag;

    assign num_mag = num[W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[W-1] ? (~den + 1'b1) : den;

    // load: scaled dividend magnitude, divisor magnitude and result sign
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg[0] <= N'(num_mag) << F;
            rem_reg[0] <= '0;
            dvs_reg[0] <= den_mag;
            neg_reg[0] <= num[W-1] ^ den[W-1];
        end
    end

    // restoring steps: dividend bits shift out of acc, quotient bits shift in
    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [W-1:0] trial;
        logic         ge;

        assign trial = {rem_reg[k-1][W-2:0], acc_reg[k-1][N-1]};
        assign ge    = trial >= dvs_reg[k-1];

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[k] <= {acc_reg[k-1][N-2:0], ge};
                neg_reg[k] <= neg_reg[k-1];
            end
        end

        if (k < N) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? (trial - dvs_reg[k-1]) : trial;
                    dvs_reg[k] <= dvs_reg[k-1];
                end
            end
        end
    end

    // saturate the magnitude and apply the sign
    assign lim = (N'(1) << (W-1)) - N'(!neg_reg[N]);
    assign mag = (acc_reg[N] > lim) ? lim : acc_reg[N];

    always_ff @(posedge aclk) begin
        if (en) begin
            quo <= neg_reg[N] ? $signed(~mag[W-1:0] + 1'b1) : $signed(mag[W-1:0]);
        end
    end

endmodule

// ===== design/hll_flux_euler_1d_core.sv =====
// HLL approximate Riemann flux for the 1-D Euler equations, streaming core.
// Depends on hll_pkg and hll_div.
//
//  port group   dir  payload (low bit first)                         request when
//  s_*          in   tdata: rho_l mom_l energy_l rho_r mom_r energy_r s_tvalid & s_tready
//  m_*          out  tdata: flux_mass flux_momentum flux_energy       m_tvalid & m_tready
//                    tuser: wave_region[1:0] invalid_state
//  cfg_*        in   data: gas_gamma (26 bits)                        cfg_valid & cfg_ready
//
// One request enters per cycle while the skid stage is empty (s_tready high); defaults are Q8.24.
// The pipeline depth is set by the three bit-serial divider pipelines and the square-root pipeline.
// aresetn is synchronous; it clears the valid bits and the skid stage and sets gas_gamma to 1.4.
// A stalled output parks one result in a skid register; the pipeline only freezes
// once that is full, so nothing is dropped or repeated.
module hll_flux_euler_1d_core
    import hll_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // rho_l, mom_l, energy_l, rho_r, mom_r, energy_r
    input  logic [((6*WORD_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // flux_mass, flux_momentum, flux_energy
    output logic [((3*WORD_BITS+7)/8)*8-1:0]       m_tdata,
    // wave_region[1:0], invalid_state
    output logic [USER_BITS-1:0]                   m_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [GAMMA_BITS-1:0]                  cfg_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready
);

    localparam int W        = WORD_BITS;
    localparam int F        = FRAC_BITS;
    localparam int N        = W + F;
    localparam int R        = (N + 1) / 2;
    localparam int DL       = N + 2;
    localparam int SQL      = R + 2;
    localparam int CW       = (R > W) ? R : W;
    localparam int OUT_BITS = ((3*W+7)/8)*8;

    typedef logic signed [W-1:0] word_t;

    localparam word_t WMAX  = word_t'((64'(1) << (W-1)) - 64'(1));
    localparam word_t WMIN  = ~WMAX;
    localparam word_t ONE_Q = word_t'(64'(1) << F);
    localparam logic [63:0] WMAX64 = (64'(1) << (W-1)) - 64'(1);
    localparam logic [GAMMA_BITS-1:0] GAMMA_RESET =
        GAMMA_BITS'(((64'd14 << FRAC_BITS) + 64'd5) / 64'd10);

    // per-side working set; tmp1/tmp2 hold stage-local intermediates
    typedef struct packed {
        word_t rho;
        word_t mom;
        word_t ener;
        word_t vel;
        word_t pres;
        word_t fl0;
        word_t fl1;
        word_t fl2;
        word_t tmp1;
        word_t tmp2;
    } side_t;

    typedef struct packed {
        logic             v;
        logic             bad;
        side_t [1:0]      sd;
    } pipe_t;

    typedef struct packed {
        logic             v;
        logic             bad;
        region_t          region;
        word_t            sl;
        word_t            sr;
        word_t            slsr;
        word_t            den;
        word_t [2:0]      diff;
        word_t [2:0]      fa;
        word_t [2:0]      fb;
        word_t [2:0]      pc;
        word_t [2:0]      sel;
    } hll_t;

    typedef struct packed {
        logic             v;
        logic             bad;
        region_t          region;
        word_t [2:0]      flux;
    } res_t;

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return word_t'(s[W-1:0]);
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return word_t'(s[W-1:0]);
    endfunction

    // magnitude product, truncated toward zero, saturated
    function automatic word_t q_mul(input word_t a, input word_t b);
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] prod;
        logic [2*W-1:0] lim;
        logic           neg;
        ma   = a[W-1] ? (~a + 1'b1) : a;
        mb   = b[W-1] ? (~b + 1'b1) : b;
        neg  = a[W-1] ^ b[W-1];
        prod = ({{W{1'b0}}, ma} * {{W{1'b0}}, mb}) >> F;
        lim  = ((2*W)'(1) << (W-1)) - (2*W)'(!neg);
        if (prod > lim) prod = lim;
        return neg ? word_t'(~prod[W-1:0] + 1'b1) : word_t'(prod[W-1:0]);
    endfunction

    logic                  en;
    logic [GAMMA_BITS-1:0] gamma_reg;
    word_t                 gam_next, gam_reg, gm1_reg;

    pipe_t a_next, a_reg, c_next, c_reg, d_next, d_reg, e_next, e_reg;
    pipe_t f_next, f_reg, g_next, g_reg, h_next, h_reg, i_next, i_reg;
    hll_t  j_next, j_reg, k_next, k_reg, l_next, l_reg, m_next, m_reg;
    res_t  z_next, z_reg;
    res_t  out_reg, skid_reg;
    logic  out_v_reg, skid_v_reg;

    pipe_t d1_reg [0:DL-1];
    pipe_t d2_reg [0:DL-2];
    pipe_t d3_reg [0:SQL-1];
    hll_t  d4_reg [0:DL-1];

    word_t vel_q [2];
    word_t t_q   [2];
    word_t snd_q [2];
    word_t q3    [3];

    // pipeline advances whenever the skid stage is free
    assign en        = !skid_v_reg;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= GAMMA_RESET;
        end else if (cfg_valid) begin
            gamma_reg <= cfg_data;
        end
    end

    // gamma clamped to the word, and gamma - 1
    always_comb begin
        if (64'(gamma_reg) > WMAX64) begin
            gam_next = WMAX;
        end else begin
            gam_next = word_t'(gamma_reg);
        end
    end

    always_ff @(posedge aclk) begin
        gam_reg <= gam_next;
        gm1_reg <= sat_sub(gam_next, ONE_Q);
    end

    // stage A: unpack request, density check
    always_comb begin
        a_next   = '0;
        a_next.v = s_tvalid;
        for (int j = 0; j < 2; j++) begin
            a_next.sd[j].rho  = word_t'(s_tdata[(3*j)*W +: W]);
            a_next.sd[j].mom  = word_t'(s_tdata[(3*j+1)*W +: W]);
            a_next.sd[j].ener = word_t'(s_tdata[(3*j+2)*W +: W]);
        end
        a_next.bad = ($signed(a_next.sd[0].rho) <= 0) || ($signed(a_next.sd[1].rho) <= 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.v <= 1'b0;
        end else if (en) begin
            a_reg <= a_next;
        end
    end

    // velocity dividers and the matching delay line
    for (genvar j = 0; j < 2; j++) begin : g_div_vel
        hll_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (a_reg.sd[j].mom),
            .den  (a_reg.sd[j].rho),
            .quo  (vel_q[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DL; i++) d1_reg[i].v <= 1'b0;
        end else if (en) begin
            d1_reg[0] <= a_reg;
            for (int i = 1; i < DL; i++) d1_reg[i] <= d1_reg[i-1];
        end
    end

    // stage C: (rho/2)*u
    always_comb begin
        c_next = d1_reg[DL-1];
        for (int j = 0; j < 2; j++) begin
            c_next.sd[j].vel  = vel_q[j];
            c_next.sd[j].tmp1 = q_mul($signed(d1_reg[DL-1].sd[j].rho) >>> 1, vel_q[j]);
        end
    end

    // stage D: kinetic energy, mass flux
    always_comb begin
        d_next = c_reg;
        for (int j = 0; j < 2; j++) begin
            d_next.sd[j].tmp1 = q_mul(c_reg.sd[j].tmp1, c_reg.sd[j].vel);
            d_next.sd[j].fl0  = q_mul(c_reg.sd[j].rho, c_reg.sd[j].vel);
        end
    end

    // stage E: internal energy, rho*u*u
    always_comb begin
        e_next = d_reg;
        for (int j = 0; j < 2; j++) begin
            e_next.sd[j].tmp1 = sat_sub(d_reg.sd[j].ener, d_reg.sd[j].tmp1);
            e_next.sd[j].tmp2 = q_mul(d_reg.sd[j].fl0, d_reg.sd[j].vel);
        end
    end

    // stage F: pressure
    always_comb begin
        f_next = e_reg;
        for (int j = 0; j < 2; j++) begin
            f_next.sd[j].pres = q_mul(gm1_reg, e_reg.sd[j].tmp1);
        end
    end

    // stage G: gamma*p, momentum flux, E+p, pressure check
    always_comb begin
        g_next = f_reg;
        for (int j = 0; j < 2; j++) begin
            g_next.sd[j].tmp1 = q_mul(gam_reg, f_reg.sd[j].pres);
            g_next.sd[j].fl1  = sat_add(f_reg.sd[j].tmp2, f_reg.sd[j].pres);
            g_next.sd[j].tmp2 = sat_add(f_reg.sd[j].ener, f_reg.sd[j].pres);
        end
        g_next.bad = f_reg.bad || f_reg.sd[0].pres[W-1] || f_reg.sd[1].pres[W-1];
    end

    // stage H: energy flux (runs beside the second divider)
    always_comb begin
        h_next = g_reg;
        for (int j = 0; j < 2; j++) begin
            h_next.sd[j].fl2 = q_mul(g_reg.sd[j].vel, g_reg.sd[j].tmp2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.v <= 1'b0;
            d_reg.v <= 1'b0;
            e_reg.v <= 1'b0;
            f_reg.v <= 1'b0;
            g_reg.v <= 1'b0;
            h_reg.v <= 1'b0;
        end else if (en) begin
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= h_next;
        end
    end

    // gamma*p/rho dividers
    for (genvar j = 0; j < 2; j++) begin : g_div_snd
        hll_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (g_reg.sd[j].tmp1),
            .den  (g_reg.sd[j].rho),
            .quo  (t_q[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DL-1; i++) d2_reg[i].v <= 1'b0;
        end else if (en) begin
            d2_reg[0] <= h_reg;
            for (int i = 1; i < DL-1; i++) d2_reg[i] <= d2_reg[i-1];
        end
    end

    // sound speed: digit-by-digit square root, one root bit per stage
    for (genvar j = 0; j < 2; j++) begin : g_sqrt
        logic [2*R-1:0] rad_reg  [0:R-1];
        logic [R+1:0]   rem_reg  [0:R-1];
        logic [R-1:0]   root_reg [0:R];

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[0]  <= ($signed(t_q[j]) > 0) ? ((2*R)'(t_q[j]) << F) : '0;
                rem_reg[0]  <= '0;
                root_reg[0] <= '0;
            end
        end

        for (genvar k = 1; k <= R; k++) begin : g_step
            logic [R+1:0] cur;
            logic [R+1:0] trial;
            logic         ge;

            assign cur   = {rem_reg[k-1][R-1:0], rad_reg[k-1][2*R-1 -: 2]};
            assign trial = {root_reg[k-1], 2'b01};
            assign ge    = cur >= trial;

            always_ff @(posedge aclk) begin
                if (en) begin
                    root_reg[k] <= {root_reg[k-1][R-2:0], ge};
                end
            end

            if (k < R) begin : g_keep
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k] <= ge ? (cur - trial) : cur;
                        rad_reg[k] <= rad_reg[k-1] << 2;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                snd_q[j] <= (CW'(root_reg[R]) > CW'(WMAX)) ? WMAX : word_t'(root_reg[R]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQL; i++) d3_reg[i].v <= 1'b0;
        end else if (en) begin
            d3_reg[0] <= d2_reg[DL-2];
            for (int i = 1; i < SQL; i++) d3_reg[i] <= d3_reg[i-1];
        end
    end

    // stage I: u-c and u+c per side
    always_comb begin
        i_next = d3_reg[SQL-1];
        for (int j = 0; j < 2; j++) begin
            i_next.sd[j].tmp1 = sat_sub(d3_reg[SQL-1].sd[j].vel, snd_q[j]);
            i_next.sd[j].tmp2 = sat_add(d3_reg[SQL-1].sd[j].vel, snd_q[j]);
        end
    end

    // stage J: wave speed bounds, state jumps
    always_comb begin
        j_next        = '0;
        j_next.v      = i_reg.v;
        j_next.bad    = i_reg.bad;
        j_next.region = REGION_LEFT;
        j_next.sl     = ($signed(i_reg.sd[0].tmp1) < $signed(i_reg.sd[1].tmp1)) ?
                        i_reg.sd[0].tmp1 : i_reg.sd[1].tmp1;
        j_next.sr     = ($signed(i_reg.sd[0].tmp2) > $signed(i_reg.sd[1].tmp2)) ?
                        i_reg.sd[0].tmp2 : i_reg.sd[1].tmp2;
        j_next.diff[0] = sat_sub(i_reg.sd[1].rho, i_reg.sd[0].rho);
        j_next.diff[1] = sat_sub(i_reg.sd[1].mom, i_reg.sd[0].mom);
        j_next.diff[2] = sat_sub(i_reg.sd[1].ener, i_reg.sd[0].ener);
        j_next.fa[0]   = i_reg.sd[0].fl0;
        j_next.fa[1]   = i_reg.sd[0].fl1;
        j_next.fa[2]   = i_reg.sd[0].fl2;
        j_next.fb[0]   = i_reg.sd[1].fl0;
        j_next.fb[1]   = i_reg.sd[1].fl1;
        j_next.fb[2]   = i_reg.sd[1].fl2;
    end

    // stage K: region pick, SL*SR, SR-SL, SR*FL and SL*FR
    always_comb begin
        k_next = j_reg;
        if (!j_reg.sl[W-1]) begin
            k_next.region = REGION_LEFT;
            k_next.sel    = j_reg.fa;
        end else if (j_reg.sr[W-1] || (j_reg.sr == '0)) begin
            k_next.region = REGION_RIGHT;
            k_next.sel    = j_reg.fb;
        end else begin
            k_next.region = REGION_HLL;
            k_next.sel    = j_reg.fa;
        end
        k_next.slsr = q_mul(j_reg.sl, j_reg.sr);
        k_next.den  = sat_sub(j_reg.sr, j_reg.sl);
        for (int n = 0; n < 3; n++) begin
            k_next.fa[n] = q_mul(j_reg.sr, j_reg.fa[n]);
            k_next.fb[n] = q_mul(j_reg.sl, j_reg.fb[n]);
        end
    end

    // stage L: SL*SR*(UR-UL), SR*FL - SL*FR
    always_comb begin
        l_next = k_reg;
        for (int n = 0; n < 3; n++) begin
            l_next.pc[n] = q_mul(k_reg.slsr, k_reg.diff[n]);
            l_next.fa[n] = sat_sub(k_reg.fa[n], k_reg.fb[n]);
        end
    end

    // stage M: HLL numerators
    always_comb begin
        m_next = l_reg;
        for (int n = 0; n < 3; n++) begin
            m_next.fa[n] = sat_add(l_reg.fa[n], l_reg.pc[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg.v <= 1'b0;
            j_reg.v <= 1'b0;
            k_reg.v <= 1'b0;
            l_reg.v <= 1'b0;
            m_reg.v <= 1'b0;
        end else if (en) begin
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            l_reg <= l_next;
            m_reg <= m_next;
        end
    end

    // HLL average dividers
    for (genvar n = 0; n < 3; n++) begin : g_div_hll
        hll_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (m_reg.fa[n]),
            .den  (m_reg.den),
            .quo  (q3[n])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DL; i++) d4_reg[i].v <= 1'b0;
        end else if (en) begin
            d4_reg[0] <= m_reg;
            for (int i = 1; i < DL; i++) d4_reg[i] <= d4_reg[i-1];
        end
    end

    // stage Z: final selection, invalid states give zero flux
    always_comb begin
        z_next     = '0;
        z_next.v   = d4_reg[DL-1].v;
        z_next.bad = d4_reg[DL-1].bad;
        if (d4_reg[DL-1].bad) begin
            z_next.region = REGION_LEFT;
            z_next.flux   = '0;
        end else begin
            z_next.region = d4_reg[DL-1].region;
            for (int n = 0; n < 3; n++) begin
                z_next.flux[n] = (d4_reg[DL-1].region == REGION_HLL) ?
                                 q3[n] : d4_reg[DL-1].sel[n];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_reg.v <= 1'b0;
        end else if (en) begin
            z_reg <= z_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!skid_v_reg) begin
            if (!out_v_reg || m_tready) begin
                out_v_reg <= z_reg.v;
                out_reg   <= z_reg;
            end else if (z_reg.v) begin
                skid_v_reg <= 1'b1;
                skid_reg   <= z_reg;
            end
        end else if (m_tready) begin
            out_reg    <= skid_reg;
            skid_v_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_BITS'({out_reg.flux[2], out_reg.flux[1], out_reg.flux[0]});
    assign m_tuser  = {out_reg.bad, out_reg.region};

    // skid only ever holds a result behind a pending output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid stage full while output register empty");

    // a taken output drains the skid stage on the next clock
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg && m_tready |=> !skid_v_reg && out_v_reg)
        else $error("skid stage failed to drain");

    // invalid states always report zero flux and the left region
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_reg.bad |-> (out_reg.flux == '0) && (out_reg.region == REGION_LEFT))
        else $error("invalid state with non-zero flux");

endmodule
